// ===== src/assert_macros.svh =====
// Assertion macros used by the blocklist top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("blocklist assertion failed");

// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("blocklist forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== src/tabl_pkg.sv =====
// Types and constants shared by the timed address blocklist modules.
`default_nettype none

package tabl_pkg;

  localparam int ADDR_W    = 32;
  localparam int AGE_W     = 17;
  localparam int TIMEOUT_W = 16;
  localparam int KIND_W    = 2;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  // Age of a slot that has never been written, or has aged out fully
  localparam logic [AGE_W-1:0]     AGE_MAX       = 17'h10000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;

  // Register index decoded from the byte address
  typedef enum logic {
    REG_TIMEOUT = 1'b0,
    REG_NONE    = 1'b1
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Verdict of the shared entry unit for one table slot
  typedef struct packed {
    logic              we;
    logic              set_valid;
    logic              found;
    logic [ADDR_W-1:0] addr;
    logic [AGE_W-1:0]  age;
  } unit_res_t;

endpackage

`default_nettype wire

// ===== src/timed_address_blocklist.sv =====
// Top level of the timed address blocklist: sequencer, slot table and result register.
`default_nettype none

// Blocklist of ENTRIES aging IPv4 addresses. Each item (tick, insert or query) is
// taken only while the block is idle and yields exactly one result. The sequencer reads
// the slots in order from slot 0: a tick, an insert that finds no expired slot and a
// query that misses go through all ENTRIES slots, while an insert that succeeds stops
// at the expired slot it claims and a query that succeeds at the live slot holding its
// address; an item of kind 3 skips the scan. The result is then loaded into the output
// register, and the input reopens in the cycle in which that result appears there. The
// scan time is set by the slot table RAM, read one slot per cycle and fed to a single
// compare/increment unit whose write-back shares the same scan. A finished result waits
// in the output register, so the next item may be accepted before it is taken; if that
// result is still waiting when the next one finishes, the new one holds in the
// sequencer and the input stays stalled. Slots start expired through per-slot valid
// flops, so no clearing pass follows reset. The timeout register sits at byte address 0
// of the APB port and is judged live at each item.
`include "assert_macros.svh"

module timed_address_blocklist #(
  parameter int ENTRIES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [tabl_pkg::KIND_W-1:0]       kind,
  input  wire logic [tabl_pkg::ADDR_W-1:0]       ip_address,
  // Result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   hit,
  output logic                                   stored,
  // Configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tabl_pkg::APB_AW-1:0]       paddr,
  input  wire logic [tabl_pkg::APB_DW-1:0]       pwdata,
  output logic      [tabl_pkg::APB_DW-1:0]       prdata,
  output logic                                   pready
);

  localparam int IDXW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW  = $clog2(ENTRIES + 1);
  localparam int WORDW = tabl_pkg::ADDR_W + tabl_pkg::AGE_W;

  localparam logic [CNTW-1:0] CNT_END  = CNTW'(ENTRIES);
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(ENTRIES - 1);

  tabl_pkg::state_t state, state_next;

  logic [tabl_pkg::TIMEOUT_W-1:0] timeout_ticks;

  logic [CNTW-1:0]              cnt;
  logic                         p_valid;
  logic [IDXW-1:0]              p_idx;
  tabl_pkg::kind_t              item_kind;
  logic [tabl_pkg::ADDR_W-1:0]  item_ip;
  logic                         found;
  logic [ENTRIES-1:0]           valid;

  logic                         in_accept;
  logic                         issue;
  logic                         load_out;
  logic                         scan_last;
  logic                         ram_we;
  logic [WORDW-1:0]             ram_rdata;
  tabl_pkg::unit_res_t          res;

  // Configuration registers
  tabl_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .timeout_ticks (timeout_ticks)
  );

  // Slot table: address above age
  tabl_ram #(
    .WIDTH (WORDW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p_idx),
    .wdata ({res.addr, res.age}),
    .raddr (cnt[IDXW-1:0]),
    .rdata (ram_rdata)
  );

  // Shared compare/increment unit on the slot just read
  tabl_unit u_unit (
    .kind          (item_kind),
    .ip_address    (item_ip),
    .ent_addr      (ram_rdata[WORDW-1:tabl_pkg::AGE_W]),
    .ent_age       (ram_rdata[tabl_pkg::AGE_W-1:0]),
    .ent_valid     (valid[p_idx]),
    .timeout_ticks (timeout_ticks),
    .res           (res)
  );

  assign in_accept = in_valid && !in_stall;
  assign scan_last = p_valid && (res.found || (p_idx == IDX_LAST));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tabl_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (tabl_pkg::kind_t'(kind) == tabl_pkg::KIND_NONE) ?
                       tabl_pkg::ST_FINISH : tabl_pkg::ST_SCAN;
        end
      end
      tabl_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = tabl_pkg::ST_FINISH;
        end
      end
      tabl_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = tabl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tabl_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    ram_we   = 1'b0;
    load_out = 1'b0;
    unique case (state)
      tabl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      tabl_pkg::ST_SCAN: begin
        issue  = (cnt < CNT_END);
        ram_we = p_valid && res.we;
      end
      tabl_pkg::ST_FINISH: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tabl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan counter, read pipeline and found flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      p_valid <= 1'b0;
      found   <= 1'b0;
    end else if (in_accept) begin
      cnt     <= '0;
      p_valid <= 1'b0;
      found   <= 1'b0;
    end else begin
      p_valid <= issue;
      if (issue) begin
        cnt <= cnt + CNTW'(1);
      end
      if ((state == tabl_pkg::ST_SCAN) && p_valid && res.found) begin
        found <= 1'b1;
      end
    end
  end

  // Hold the item and the index of the slot in flight
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_kind <= tabl_pkg::kind_t'(kind);
      item_ip   <= ip_address;
    end
    p_idx <= cnt[IDXW-1:0];
  end

  // Mark slots written by an insert
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ram_we && res.set_valid) begin
      valid[p_idx] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      hit    <= found && (item_kind == tabl_pkg::KIND_QUERY);
      stored <= found && (item_kind == tabl_pkg::KIND_INSERT);
    end
  end

  // Checks on the sequencer
  `ASSERT_NEVER(a_one_flag, clk, rst, out_valid && hit && stored)
  `ASSERT_PROP(a_write_in_scan, clk, rst, ram_we |-> (state == tabl_pkg::ST_SCAN))
  `ASSERT_PROP(a_busy_after_accept, clk, rst, in_accept |=> (state != tabl_pkg::ST_IDLE))
  `ASSERT_PROP(a_finish_loads, clk, rst, load_out |=> (out_valid && (state == tabl_pkg::ST_IDLE)))

endmodule

`default_nettype wire

// ===== src/tabl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tabl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/tabl_cfg.sv =====
// APB-style configuration register bank holding the timeout.
`default_nettype none

module tabl_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tabl_pkg::APB_AW-1:0]   paddr,
  input  wire logic [tabl_pkg::APB_DW-1:0]   pwdata,
  output logic      [tabl_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  output logic      [tabl_pkg::TIMEOUT_W-1:0] timeout_ticks
);

  tabl_pkg::reg_idx_t reg_idx;
  logic               wr_strobe;

  // Decode the register index from bit 2 of the byte address
  assign reg_idx   = tabl_pkg::reg_idx_t'(paddr[2]);
  assign pready    = 1'b1;
  assign wr_strobe = psel && penable && pwrite && pready;

  // Update the timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= tabl_pkg::TIMEOUT_RESET;
    end else if (wr_strobe && (reg_idx == tabl_pkg::REG_TIMEOUT)) begin
      timeout_ticks <= pwdata[tabl_pkg::TIMEOUT_W-1:0];
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      tabl_pkg::REG_TIMEOUT: begin
        prdata = {{(tabl_pkg::APB_DW - tabl_pkg::TIMEOUT_W){1'b0}}, timeout_ticks};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tabl_unit.sv =====
// Shared per-slot unit: expiry compare, address compare and age increment.
`default_nettype none

module tabl_unit (
  input  wire logic [tabl_pkg::KIND_W-1:0]    kind,
  input  wire logic [tabl_pkg::ADDR_W-1:0]    ip_address,
  input  wire logic [tabl_pkg::ADDR_W-1:0]    ent_addr,
  input  wire logic [tabl_pkg::AGE_W-1:0]     ent_age,
  input  wire logic                           ent_valid,
  input  wire logic [tabl_pkg::TIMEOUT_W-1:0] timeout_ticks,
  output tabl_pkg::unit_res_t                 res
);

  logic [tabl_pkg::AGE_W-1:0] age_eff;
  logic                       expired;
  logic                       saturated;

  // An unwritten slot reads as fully aged
  assign age_eff   = ent_valid ? ent_age : tabl_pkg::AGE_MAX;
  assign expired   = age_eff > {1'b0, timeout_ticks};
  assign saturated = age_eff[tabl_pkg::AGE_W-1];

  always_comb begin
    res = '{we: 1'b0, set_valid: 1'b0, found: 1'b0, addr: ent_addr, age: age_eff};
    case (tabl_pkg::kind_t'(kind))
      tabl_pkg::KIND_TICK: begin
        // Advance the age of a written slot until it saturates
        res.we  = ent_valid && !saturated;
        res.age = age_eff + tabl_pkg::AGE_W'(1);
      end
      tabl_pkg::KIND_INSERT: begin
        // Claim the slot if it has expired
        res.we        = expired;
        res.set_valid = expired;
        res.found     = expired;
        res.addr      = ip_address;
        res.age       = '0;
      end
      tabl_pkg::KIND_QUERY: begin
        res.found = !expired && (ent_addr == ip_address);
      end
      default: begin
        res.we = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire
